// ----- src/pidvdt_pkg.sv -----
// Shared widths, register indexes, sequencer states and control types for the PID block.
package pidvdt_pkg;

  localparam int DATA_W     = 16;
  localparam int TIME_W     = 20;
  localparam int INTEG_W    = 48;
  localparam int ERR_W      = DATA_W + 1;
  localparam int DIFF_W     = DATA_W + 2;
  localparam int MAG_W      = DIFF_W - 1;
  localparam int ACC_W      = 64;
  localparam int MPY_W      = ERR_W;
  localparam int CNT_W      = 5;
  localparam int OUT_SHIFT  = 16;
  localparam int QUO_W      = ACC_W - OUT_SHIFT;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD = 2'd2;

  localparam logic signed [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0]  DRIVE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0]  DRIVE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INTEG,
    ST_PROP,
    ST_DERIV,
    ST_IGAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic load;
  } mul_cmd_t;

endpackage

// ----- src/pidvdt_mul.sv -----
// Bit-serial signed shift-add multiplier with a seeded running accumulator.
module pidvdt_mul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  pidvdt_pkg::mul_cmd_t                    cmd,
  input  logic signed [pidvdt_pkg::ACC_W-1:0]     mcand,
  input  logic signed [pidvdt_pkg::MPY_W-1:0]     mplier,
  input  logic signed [pidvdt_pkg::ACC_W-1:0]     seed,
  output logic signed [pidvdt_pkg::ACC_W-1:0]     acc,
  output logic                                    done
);
  import pidvdt_pkg::*;

  logic signed [ACC_W-1:0] mc_sh;
  logic        [MPY_W-1:0] mp_sh;
  logic        [CNT_W-1:0] cnt;
  logic                    busy;
  logic                    last;
  logic signed [ACC_W-1:0] addend;

  assign last   = busy && (cnt == CNT_W'(MPY_W - 1));
  assign addend = mp_sh[0] ? mc_sh : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= last;
      if (cmd.start) begin
        mc_sh <= mcand;
        mp_sh <= mplier;
        cnt   <= '0;
        busy  <= 1'b1;
        if (cmd.load) begin
          acc <= seed;
        end
      end else if (busy) begin
        acc   <= last ? acc - addend : acc + addend;
        mc_sh <= mc_sh <<< 1;
        mp_sh <= mp_sh >> 1;
        cnt   <= cnt + CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/pidvdt_div.sv -----
// Restoring bit-serial divider for the error difference over the elapsed interval.
module pidvdt_div (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [pidvdt_pkg::DIFF_W-1:0]    dividend,
  input  logic        [pidvdt_pkg::TIME_W-1:0]    divisor,
  output logic signed [pidvdt_pkg::DIFF_W-1:0]    quotient
);
  import pidvdt_pkg::*;

  logic        [MAG_W-1:0]  mag;
  logic        [MAG_W-1:0]  quo;
  logic        [TIME_W-1:0] rem;
  logic        [TIME_W-1:0] dvs;
  logic        [CNT_W-1:0]  cnt;
  logic                     busy;
  logic                     neg;
  logic                     zero_div;
  logic        [TIME_W:0]   trial;
  logic                     ge;
  logic        [DIFF_W-1:0] neg_dividend;
  logic signed [DIFF_W-1:0] quo_ext;

  assign trial        = {rem, mag[MAG_W-1]};
  assign ge           = trial >= {1'b0, dvs};
  assign neg_dividend = -dividend;
  assign quo_ext      = {1'b0, quo};

  always_comb begin
    if (zero_div) begin
      quotient = '0;
    end else if (neg) begin
      quotient = -quo_ext;
    end else begin
      quotient = quo_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      neg      <= dividend[DIFF_W-1];
      mag      <= dividend[DIFF_W-1] ? neg_dividend[MAG_W-1:0] : dividend[MAG_W-1:0];
      dvs      <= divisor;
      zero_div <= (divisor == '0);
      rem      <= '0;
      quo      <= '0;
      cnt      <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      rem <= ge ? TIME_W'(trial - {1'b0, dvs}) : trial[TIME_W-1:0];
      quo <= {quo[MAG_W-2:0], ge};
      mag <= mag << 1;
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ----- src/pid_controller_variable_dt_top.sv -----
// Top level: PID step with variable interval, serial multiply and divide, output register.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------------------------
//  in       | in_valid / in_stall   | target_value, measured_value, elapsed_us
//  out      | out_valid / out_stall | drive_value, saturated
//  cfg      | cfg_write             | cfg_index, cfg_data
//
// A transaction runs from acceptance to the next acceptance as four passes of the shared
// bit-serial multiplier with a handoff after each, an output step, and an idle step in
// which the next transaction is taken.
// The divider runs alongside the first pass.
// Reset clears gains, integral and previous error. A new transaction is taken while
// a result still waits in the output register; a stalled result holds the last step.
module pid_controller_variable_dt_top (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [pidvdt_pkg::DATA_W-1:0]     target_value,
  input  logic signed [pidvdt_pkg::DATA_W-1:0]     measured_value,
  input  logic        [pidvdt_pkg::TIME_W-1:0]     elapsed_us,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [pidvdt_pkg::DATA_W-1:0]     drive_value,
  output logic                                     saturated,
  input  logic                                     cfg_write,
  input  logic        [pidvdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pidvdt_pkg::DATA_W-1:0]     cfg_data
);
  import pidvdt_pkg::*;

  state_t state;
  state_t state_next;

  logic signed [DATA_W-1:0]  gain_kp;
  logic signed [DATA_W-1:0]  gain_ki;
  logic signed [DATA_W-1:0]  gain_kd;
  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   prev_err;
  logic signed [ERR_W-1:0]   err_r;
  logic                      sat_r;

  logic                      accept;
  logic signed [ERR_W-1:0]   err_in;
  logic signed [DIFF_W-1:0]  diff_in;

  mul_cmd_t                  mul_cmd;
  logic signed [ACC_W-1:0]   mul_mcand;
  logic signed [MPY_W-1:0]   mul_mplier;
  logic signed [ACC_W-1:0]   mul_seed;
  logic signed [ACC_W-1:0]   acc;
  logic                      mul_done;
  logic signed [DIFF_W-1:0]  deriv;

  logic                      integ_update;
  logic [ACC_W-INTEG_W:0]    integ_top;
  logic                      integ_fits;
  logic signed [INTEG_W-1:0] integ_clamped;

  logic                      load_out;
  logic signed [QUO_W-1:0]   scaled;
  logic [QUO_W-DATA_W:0]     drive_top;
  logic                      drive_fits;
  logic signed [DATA_W-1:0]  drive_clamped;

  assign accept  = in_valid && !in_stall;
  assign err_in  = ERR_W'(target_value) - ERR_W'(measured_value);
  assign diff_in = DIFF_W'(err_in) - DIFF_W'(prev_err);

  pidvdt_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .cmd    (mul_cmd),
    .mcand  (mul_mcand),
    .mplier (mul_mplier),
    .seed   (mul_seed),
    .acc    (acc),
    .done   (mul_done)
  );

  pidvdt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (diff_in),
    .divisor  (elapsed_us),
    .quotient (deriv)
  );

  assign integ_top     = acc[ACC_W-1:INTEG_W-1];
  assign integ_fits    = (&integ_top) || !(|integ_top);
  assign integ_clamped = integ_fits ? acc[INTEG_W-1:0] : (acc[ACC_W-1] ? INTEG_MIN : INTEG_MAX);

  assign scaled        = acc[ACC_W-1:OUT_SHIFT]
                         + QUO_W'(acc[ACC_W-1] && (|acc[OUT_SHIFT-1:0]));
  assign drive_top     = scaled[QUO_W-1:DATA_W-1];
  assign drive_fits    = (&drive_top) || !(|drive_top);
  assign drive_clamped = drive_fits ? scaled[DATA_W-1:0]
                                    : (scaled[QUO_W-1] ? DRIVE_MIN : DRIVE_MAX);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_INTEG;
      ST_INTEG:  if (mul_done) state_next = ST_PROP;
      ST_PROP:   if (mul_done) state_next = ST_DERIV;
      ST_DERIV:  if (mul_done) state_next = ST_IGAIN;
      ST_IGAIN:  if (mul_done) state_next = ST_FINISH;
      ST_FINISH: if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    mul_cmd      = '0;
    mul_mcand    = '0;
    mul_mplier   = '0;
    mul_seed     = '0;
    integ_update = 1'b0;
    load_out     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        mul_cmd.start = accept;
        mul_cmd.load  = 1'b1;
        mul_mcand     = ACC_W'(elapsed_us);
        mul_mplier    = err_in;
        mul_seed      = ACC_W'(integral_sum);
      end
      ST_INTEG: begin
        integ_update  = mul_done;
        mul_cmd.start = mul_done;
        mul_cmd.load  = 1'b1;
        mul_mcand     = ACC_W'(err_r);
        mul_mplier    = MPY_W'(gain_kp);
      end
      ST_PROP: begin
        mul_cmd.start = mul_done;
        mul_mcand     = ACC_W'(deriv);
        mul_mplier    = MPY_W'(gain_kd);
      end
      ST_DERIV: begin
        mul_cmd.start = mul_done;
        mul_mcand     = ACC_W'(integral_sum);
        mul_mplier    = MPY_W'(gain_ki);
      end
      ST_IGAIN: begin
      end
      ST_FINISH: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      gain_kp      <= '0;
      gain_ki      <= '0;
      gain_kd      <= '0;
      integral_sum <= '0;
      prev_err     <= '0;
      sat_r        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_KP:  gain_kp <= cfg_data;
          CFG_KI:  gain_ki <= cfg_data;
          CFG_KD:  gain_kd <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        err_r    <= err_in;
        prev_err <= err_in;
        sat_r    <= 1'b0;
      end
      if (integ_update) begin
        integral_sum <= integ_clamped;
        sat_r        <= !integ_fits;
      end
      if (load_out) begin
        out_valid   <= 1'b1;
        drive_value <= drive_clamped;
        saturated   <= sat_r || !drive_fits;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/sv/pid_step_checker.sv -----
// Checker for the PID step block: predicts each drive result and compares it on the output channel.
module pid_step_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_stall,
  input  logic signed [pidvdt_pkg::DATA_W-1:0]    target_value,
  input  logic signed [pidvdt_pkg::DATA_W-1:0]    measured_value,
  input  logic        [pidvdt_pkg::TIME_W-1:0]    elapsed_us,
  input  logic                                    out_valid,
  input  logic                                    out_stall,
  input  logic signed [pidvdt_pkg::DATA_W-1:0]    drive_value,
  input  logic                                    saturated,
  input  logic                                    cfg_write,
  input  logic        [pidvdt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [pidvdt_pkg::DATA_W-1:0]    cfg_data,
  output int                                      fail_count,
  output int                                      pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pidvdt_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] drive;
    logic              sat;
  } drive_result_t;

  logic signed [DATA_W-1:0]  kp;
  logic signed [DATA_W-1:0]  ki;
  logic signed [DATA_W-1:0]  kd;
  logic signed [INTEG_W-1:0] integ;
  logic signed [ERR_W-1:0]   prev_err;
  logic                      clip_hit;
  drive_result_t             drive_expect_q[$];

  function automatic logic signed [127:0] clip(input logic signed [127:0] v, input int w);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (w - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) begin
      clip_hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      clip_hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic drive_result_t pid_step(input logic signed [DATA_W-1:0] tgt,
                                             input logic signed [DATA_W-1:0] meas,
                                             input logic [TIME_W-1:0] dt);
    logic signed [127:0] err;
    logic signed [127:0] span;
    logic signed [127:0] deriv;
    logic signed [127:0] term;
    logic signed [127:0] acc;
    drive_result_t       r;
    clip_hit = 1'b0;
    err = tgt - meas;
    span = dt;
    term = err * span;
    term = clip(term, 64);
    acc = integ + term;
    acc = clip(acc, 64);
    acc = clip(acc, INTEG_W);
    integ = acc[INTEG_W-1:0];
    deriv = 0;
    if (dt != 0) begin
      deriv = err - prev_err;
      deriv = deriv / span;
    end
    prev_err = err[ERR_W-1:0];
    acc = kp * err;
    acc = clip(acc, 64);
    term = ki * integ;
    term = clip(term, 64);
    acc = acc + term;
    acc = clip(acc, 64);
    term = kd * deriv;
    term = clip(term, 64);
    acc = acc + term;
    acc = clip(acc, 64);
    acc = acc / 128'sd65536;
    acc = clip(acc, DATA_W);
    r.drive = acc[DATA_W-1:0];
    r.sat = clip_hit;
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    if (rst) begin
      kp = '0;
      ki = '0;
      kd = '0;
      integ = '0;
      prev_err = '0;
      drive_expect_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_KP: kp = cfg_data;
          CFG_KI: ki = cfg_data;
          CFG_KD: kd = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        drive_expect_q.push_back(pid_step(target_value, measured_value, elapsed_us));
      if (out_valid && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result drive_value %0d saturated %0d",
                   $time, drive_value, saturated);
        end else begin
          want = drive_expect_q.pop_front();
          if (drive_value !== want.drive) begin
            fail_count++;
            $display("%0t: drive_value expected %0d actual %0d",
                     $time, $signed(want.drive), drive_value);
          end
          if (saturated !== want.sat) begin
            fail_count++;
            $display("%0t: saturated expected %0d actual %0d", $time, want.sat, saturated);
          end
        end
      end
    end
    pending = drive_expect_q.size();
  end

endmodule

// ----- tb/sv/tb_pid_controller_variable_dt_top.sv -----
// Testbench top: drives PID steps and gain writes into the block and reports the verdict.
module tb_pid_controller_variable_dt_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pidvdt_pkg::*;

  localparam logic signed [DATA_W-1:0] VAL_MAX   = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] VAL_MIN   = 16'sh8000;
  localparam logic        [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic     [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int                       LIMIT     = 3000000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [DATA_W-1:0] target_value = '0;
  logic signed [DATA_W-1:0] measured_value = '0;
  logic        [TIME_W-1:0] elapsed_us = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] drive_value;
  logic                     saturated;
  logic                     cfg_write = 1'b0;
  logic     [CFG_IDX_W-1:0] cfg_index = '0;
  logic        [DATA_W-1:0] cfg_data = '0;
  int                       fail_count;
  int                       pending;
  int                       cycles = 0;
  int                       hold_left = 0;
  logic                     calm = 1'b0;

  pid_controller_variable_dt_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_value(target_value), .measured_value(measured_value), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_value(drive_value), .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pid_step_checker step_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_value(target_value), .measured_value(measured_value), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_stall(out_stall),
    .drive_value(drive_value), .saturated(saturated),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("pid_controller_variable_dt_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst || calm) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(4999) == 0) begin
      hold_left = int'($urandom_range(200, 80));
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < 26);
    end
  end

  task automatic send_step(input logic signed [DATA_W-1:0] t,
                           input logic signed [DATA_W-1:0] m,
                           input logic [TIME_W-1:0] e);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    target_value <= t;
    measured_value <= m;
    elapsed_us <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic set_gains(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] i,
                           input logic [DATA_W-1:0] d);
    write_reg(CFG_KP, p);
    write_reg(CFG_KI, i);
    write_reg(CFG_KD, d);
    write_reg(CFG_SPARE, DATA_W'($urandom));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0: return DATA_W'($urandom);
      1: return DATA_W'($urandom_range(1023)) - DATA_W'(512);
      2: return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      default: return DATA_W'($urandom_range(255));
    endcase
  endfunction

  task automatic rand_step();
    logic signed [DATA_W-1:0] t;
    logic signed [DATA_W-1:0] m;
    logic        [TIME_W-1:0] e;
    t = DATA_W'($urandom);
    m = DATA_W'($urandom);
    e = TIME_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: ;
      4, 5: e = TIME_W'($urandom_range(8));
      6: e = '0;
      7: begin
        t = $urandom_range(1) ? VAL_MAX : VAL_MIN;
        m = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      end
      8: m = t + 16'($urandom_range(64)) - 16'd32;
      default: e = TIME_MAX - TIME_W'($urandom_range(1000));
    endcase
    send_step(t, m, e);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_step(VAL_MAX, VAL_MIN, TIME_MAX);
    send_step(16'sd0, 16'sd0, '0);

    drain();
    set_gains(16'sh0100, 16'sh0001, 16'sh0100);
    send_step(16'sh0100, 16'sd0, 20'd10);
    send_step(16'sh0100, 16'sd0, '0);
    send_step(-16'sh0100, 16'sh0100, 20'd3);
    send_step(VAL_MIN, VAL_MAX, 20'd1);
    send_step(VAL_MAX, VAL_MIN, 20'd1);
    send_step(VAL_MAX, VAL_MIN, '0);
    send_step(VAL_MIN, VAL_MAX, TIME_MAX);
    send_step(16'sd0, 16'sd0, TIME_MAX);
    send_step(-16'sd1, 16'sd0, 20'd7);
    send_step(16'sd1, 16'sd0, 20'd7);
    send_step(VAL_MAX, VAL_MAX, 20'd5);
    send_step(VAL_MIN, VAL_MIN, 20'd5);

    drain();
    set_gains(VAL_MAX, VAL_MIN, VAL_MAX);
    send_step(VAL_MAX, VAL_MIN, 20'd1);
    send_step(VAL_MIN, VAL_MAX, 20'd1);
    send_step(16'sd0, 16'sd0, '0);
    send_step(16'sh1234, 16'sh0ff0, '0);
    send_step(VAL_MAX, VAL_MIN, TIME_MAX);
    send_step(VAL_MIN, VAL_MAX, 20'd2);

    drain();
    set_gains(VAL_MIN, VAL_MAX, VAL_MIN);
    send_step(VAL_MAX, 16'sd0, TIME_MAX);
    send_step(16'sd0, VAL_MAX, 20'd1);
    send_step(VAL_MIN, 16'sd0, '0);

    for (int p = 0; p < 5; p++) begin
      drain();
      calm = (p == 2);
      set_gains(pick_gain(), pick_gain(), pick_gain());
      repeat (140) rand_step();
    end

    drain();
    if (fail_count == 0)
      $display("pid_controller_variable_dt_top verification clean");
    else
      $display("pid_controller_variable_dt_top verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/pidvdt_pkg.sv
src/pidvdt_mul.sv
src/pidvdt_div.sv
src/pid_controller_variable_dt_top.sv
tb/sv/pid_step_checker.sv
tb/sv/tb_pid_controller_variable_dt_top.sv
